FILE: rtl/otp_pkg.sv
// Package: shared types and constants of the one-shot timer pool.
package otp_pkg;

   // Widths of the fixed request and response fields.
   localparam int DURATION_W = 16;
   localparam int TAG_W      = 8;
   localparam int KIND_W     = 2;
   localparam int SLOT_W     = 3;

   // Request kinds.
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // Response kinds.
   localparam logic [KIND_W-1:0] RK_START   = 2'd0;
   localparam logic [KIND_W-1:0] RK_EXPIRED = 2'd1;
   localparam logic [KIND_W-1:0] RK_DONE    = 2'd2;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/otp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module otp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/one_shot_timer_pool.sv
// Top level: one-shot countdown timer pool with RAM-held slot state.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+-----------------------------------------
//  request  | start & !busy             | req_kind, req_duration, req_handler_tag
//  response | rsp_strobe (one cycle)    | rsp_result_kind, rsp_slot, rsp_pool_full,
//           |                           | rsp_expired_tag, rsp_source_running,
//           |                           | rsp_last
//
// Walk: the sequencer walks the slot RAMs one slot per cycle after a read fetch.
// A start beat stops at the first free slot, or after the last slot when the pool is
// full; a tick beat goes through the fetch, a check of every slot, then tick done.
// Each response beat is registered and leaves in the cycle after the state that
// made it (its slot check, or tick done).
// Reset: synchronous, active high; clears the sequencer, the per-slot valid bits
// (an unwritten count reads as zero, so every slot starts free) and the tick
// source flag. No clearing pass is needed.
// Stalls: the response side cannot stall; busy is high from accept until the
// last response beat has been registered.
module one_shot_timer_pool
   import otp_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  start,
   output logic                  busy,
   input  logic                  req_kind,
   input  logic [DURATION_W-1:0] req_duration,
   input  logic [TAG_W-1:0]      req_handler_tag,

   output logic                  rsp_strobe,
   output logic [KIND_W-1:0]     rsp_result_kind,
   output logic [SLOT_W-1:0]     rsp_slot,
   output logic                  rsp_pool_full,
   output logic [TAG_W-1:0]      rsp_expired_tag,
   output logic                  rsp_source_running,
   output logic                  rsp_last
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // Sequencer and latched request
   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  kind_ff, kind_in;
   logic [DURATION_W-1:0] dur_ff, dur_in;
   logic [TAG_W-1:0]      tag_ff, tag_in;
   logic                  any_ff, any_in;       // some slot was counting this tick
   logic                  enabled_ff, enabled_in;
   logic [SLOTS-1:0]      valid_ff, valid_in;   // slot RAM entry has been written

   // Response register
   logic                  strobe_ff, strobe_in;
   logic [KIND_W-1:0]     rkind_ff, rkind_in;
   logic [SLOT_W-1:0]     rslot_ff, rslot_in;
   logic                  rfull_ff, rfull_in;
   logic [TAG_W-1:0]      rtag_ff, rtag_in;
   logic                  rrun_ff, rrun_in;
   logic                  rlast_ff, rlast_in;

   // RAM ports
   logic                  wr_en;
   logic [DURATION_W-1:0] wr_count;
   logic [IDX_W-1:0]      rd_addr;
   logic [DURATION_W-1:0] count_q;
   logic [TAG_W-1:0]      tag_q;
   logic [DURATION_W-1:0] count_cur;
   logic [5:0]            idx_wide;
   logic                  accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   otp_ram #(.WIDTH(DURATION_W), .DEPTH(SLOTS)) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_count),
      .rd_addr (rd_addr),
      .rd_data (count_q)
   );

   // Tags are only written by a start; a tick never rewrites them.
   otp_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en && (kind_ff == REQ_START)),
      .wr_addr (idx_ff),
      .wr_data (tag_ff),
      .rd_addr (rd_addr),
      .rd_data (tag_q)
   );

   // A never-written count entry reads as zero (free slot).
   assign count_cur = valid_ff[idx_ff] ? count_q : '0;
   assign idx_wide  = 6'(idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         enabled_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         enabled_ff <= enabled_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      kind_ff  <= kind_in;
      dur_ff   <= dur_in;
      tag_ff   <= tag_in;
      any_ff   <= any_in;
      rkind_ff <= rkind_in;
      rslot_ff <= rslot_in;
      rfull_ff <= rfull_in;
      rtag_ff  <= rtag_in;
      rrun_ff  <= rrun_in;
      rlast_ff <= rlast_in;
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      kind_in    = kind_ff;
      dur_in     = dur_ff;
      tag_in     = tag_ff;
      any_in     = any_ff;
      enabled_in = enabled_ff;
      valid_in   = valid_ff;

      strobe_in  = 1'b0;
      rkind_in   = RK_START;
      rslot_in   = '0;
      rfull_in   = 1'b0;
      rtag_in    = '0;
      rrun_in    = enabled_ff;
      rlast_in   = 1'b0;

      wr_en      = 1'b0;
      wr_count   = count_cur - DURATION_W'(1);
      rd_addr    = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req_kind;
               dur_in   = req_duration;
               tag_in   = req_handler_tag;
               idx_in   = '0;
               any_in   = 1'b0;
               state_in = ST_FETCH;
            end
         end

         ST_FETCH: begin
            // Read of slot idx_ff is in flight.
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            // Prefetch the next slot while this one is checked and written back.
            rd_addr = idx_ff + IDX_W'(1);
            if (kind_ff == REQ_START) begin
               priority if (count_cur == '0) begin
                  wr_en            = 1'b1;
                  wr_count         = dur_ff;
                  valid_in[idx_ff] = 1'b1;
                  enabled_in       = 1'b1;
                  strobe_in        = 1'b1;
                  rslot_in         = idx_wide[SLOT_W-1:0];
                  rrun_in          = 1'b1;
                  rlast_in         = 1'b1;
                  state_in         = ST_IDLE;
               end else if (idx_ff == LAST_IDX) begin
                  // Pool full: nothing stored.
                  strobe_in = 1'b1;
                  rfull_in  = 1'b1;
                  rlast_in  = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else begin
               if (count_cur != '0) begin
                  wr_en  = 1'b1;
                  any_in = 1'b1;
                  // A counting slot implies the source is running.
                  if (count_cur == DURATION_W'(1)) begin
                     strobe_in = 1'b1;
                     rkind_in  = RK_EXPIRED;
                     rslot_in  = idx_wide[SLOT_W-1:0];
                     rtag_in   = tag_q;
                  end
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end

         ST_DONE: begin
            enabled_in = any_ff && enabled_ff;
            strobe_in  = 1'b1;
            rkind_in   = RK_DONE;
            rrun_in    = any_ff && enabled_ff;
            rlast_in   = 1'b1;
            state_in   = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_result_kind    = rkind_ff;
   assign rsp_slot           = rslot_ff;
   assign rsp_pool_full      = rfull_ff;
   assign rsp_expired_tag    = rtag_ff;
   assign rsp_source_running = rrun_ff;
   assign rsp_last           = rlast_ff;

endmodule

FILE: bench/one_shot_timer_pool_test.sv
// Testbench: one-shot timer pool, directed table plus random start/tick bursts, scoreboarded.
`timescale 1ns / 1ps

module one_shot_timer_pool_test
   import otp_pkg::*;
();

   localparam int POOL_SLOTS = 8;
   localparam int ITEMS      = 410;   // request beats at least, table included; bursts may overrun

   // One response beat, in port order.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic              full;
      logic [TAG_W-1:0]  tag;
      logic              running;
      logic              last;
   } rsp_type;

   // One row of the directed table. Rows with known set carry their single
   // response beat typed in; the rest go through the pool predictor.
   typedef struct packed {
      logic                  kind;
      logic [DURATION_W-1:0] dur;
      logic [TAG_W-1:0]      tag;
      logic                  known;
      logic [KIND_W-1:0]     rk;
      logic [SLOT_W-1:0]     slot;
      logic                  full;
      logic                  running;
   } row_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_kind;
   logic [DURATION_W-1:0] req_duration;
   logic [TAG_W-1:0]      req_handler_tag;
   logic                  rsp_strobe;
   logic [KIND_W-1:0]     rsp_result_kind;
   logic [SLOT_W-1:0]     rsp_slot;
   logic                  rsp_pool_full;
   logic [TAG_W-1:0]      rsp_expired_tag;
   logic                  rsp_source_running;
   logic                  rsp_last;

   one_shot_timer_pool #(
      .SLOTS(POOL_SLOTS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_duration      (req_duration),
      .req_handler_tag   (req_handler_tag),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_slot          (rsp_slot),
      .rsp_pool_full     (rsp_pool_full),
      .rsp_expired_tag   (rsp_expired_tag),
      .rsp_source_running(rsp_source_running),
      .rsp_last          (rsp_last)
   );

   // Directed table. Early rows walk the special cases: tick while stopped,
   // zero duration (slot claimed but stays free), fill all eight slots with
   // one-tick counts, a start into a full pool, then the tick that expires
   // every slot at once (the longest response train). The tail parks the
   // largest durations in slots 0 and 1; they stay counting for the rest of
   // the run, so the random part works on the upper six slots.
   row_type plan [21] = '{
      '{REQ_TICK,  16'h0000, 8'h00, 1'b1, RK_DONE,  3'd0, 1'b0, 1'b0},
      '{REQ_START, 16'h0000, 8'hFF, 1'b1, RK_START, 3'd0, 1'b0, 1'b1},
      '{REQ_TICK,  16'hFFFF, 8'hFF, 1'b1, RK_DONE,  3'd0, 1'b0, 1'b0},
      '{REQ_START, 16'h0001, 8'h01, 1'b1, RK_START, 3'd0, 1'b0, 1'b1},
      '{REQ_START, 16'h0001, 8'h02, 1'b1, RK_START, 3'd1, 1'b0, 1'b1},
      '{REQ_START, 16'h0001, 8'h04, 1'b1, RK_START, 3'd2, 1'b0, 1'b1},
      '{REQ_START, 16'h0001, 8'h08, 1'b1, RK_START, 3'd3, 1'b0, 1'b1},
      '{REQ_START, 16'h0001, 8'h10, 1'b1, RK_START, 3'd4, 1'b0, 1'b1},
      '{REQ_START, 16'h0001, 8'h20, 1'b1, RK_START, 3'd5, 1'b0, 1'b1},
      '{REQ_START, 16'h0001, 8'h40, 1'b1, RK_START, 3'd6, 1'b0, 1'b1},
      '{REQ_START, 16'h0001, 8'h80, 1'b1, RK_START, 3'd7, 1'b0, 1'b1},
      '{REQ_START, 16'hFFFF, 8'hFF, 1'b1, RK_START, 3'd0, 1'b1, 1'b1},
      '{REQ_TICK,  16'h1234, 8'h00, 1'b0, RK_DONE,  3'd0, 1'b0, 1'b0},
      '{REQ_TICK,  16'h0000, 8'h00, 1'b1, RK_DONE,  3'd0, 1'b0, 1'b0},
      '{REQ_START, 16'hFFFF, 8'hA5, 1'b1, RK_START, 3'd0, 1'b0, 1'b1},
      '{REQ_START, 16'h8000, 8'h5A, 1'b1, RK_START, 3'd1, 1'b0, 1'b1},
      '{REQ_START, 16'h0002, 8'h00, 1'b1, RK_START, 3'd2, 1'b0, 1'b1},
      '{REQ_START, 16'h0001, 8'hC3, 1'b1, RK_START, 3'd3, 1'b0, 1'b1},
      '{REQ_TICK,  16'h5555, 8'h00, 1'b0, RK_DONE,  3'd0, 1'b0, 1'b0},
      '{REQ_TICK,  16'hAAAA, 8'h00, 1'b0, RK_DONE,  3'd0, 1'b0, 1'b0},
      '{REQ_TICK,  16'h0000, 8'h00, 1'b0, RK_DONE,  3'd0, 1'b0, 1'b0}
   };

   // Predictor state: what the pool should hold right now.
   logic [DURATION_W-1:0] count_left [POOL_SLOTS];
   logic [TAG_W-1:0]      tag_held   [POOL_SLOTS];
   logic                  tick_on;

   rsp_type due_beats [$];   // response beats still owed by the block, oldest first
   rsp_type fresh     [$];   // beats caused by the request just accepted

   int  issued;
   int  ticks_sent;
   int  beats_seen;
   int  expiries;
   int  full_replies;
   int  mismatches;
   bit  steady;           // burst runs back to back, no idling

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop: far above the slowest legal run.
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic rsp_type beat_of(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                       logic full, logic [TAG_W-1:0] tag);
      rsp_type b;
      b = '{kind, slot, full, tag, 1'b0, 1'b0};
      return b;
   endfunction

   // Pool predictor: applies one request beat to the state above and leaves
   // the response beats it causes in fresh.
   task automatic run_pool(input logic kind, input logic [DURATION_W-1:0] dur,
                           input logic [TAG_W-1:0] tag);
      int found;
      bit any;
      found = -1;
      any   = 1'b0;
      if (kind == REQ_START) begin
         // lowest slot with a zero count wins
         for (int i = POOL_SLOTS - 1; i >= 0; i--)
            if (count_left[i] == '0) found = i;
         if (found < 0) begin
            fresh.push_back(beat_of(RK_START, '0, 1'b1, '0));
         end else begin
            count_left[found] = dur;
            tag_held[found]   = tag;
            tick_on           = 1'b1;
            fresh.push_back(beat_of(RK_START, SLOT_W'(found), 1'b0, '0));
         end
      end else begin
         for (int i = 0; i < POOL_SLOTS; i++) begin
            if (count_left[i] != '0) begin
               count_left[i] = count_left[i] - 1'b1;
               any = 1'b1;
               if (count_left[i] == '0)
                  fresh.push_back(beat_of(RK_EXPIRED, SLOT_W'(i), 1'b0, tag_held[i]));
            end
         end
         // nothing counting: tick source goes quiet
         if (!any) tick_on = 1'b0;
         fresh.push_back(beat_of(RK_DONE, '0, 1'b0, '0));
      end
      foreach (fresh[k]) begin
         fresh[k].running = tick_on;
         fresh[k].last    = (k == fresh.size() - 1);
      end
   endtask

   // Idle cycles after a beat: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // Durations: mostly a few ticks so slots turn over, some zero, rare long ones.
   function automatic logic [DURATION_W-1:0] pick_duration();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return '0;
      if (r < 80) return DURATION_W'($urandom_range(1, 4));
      if (r < 95) return DURATION_W'($urandom_range(5, 20));
      return DURATION_W'($urandom_range(21, 200));
   endfunction

   // Presents one request beat from the current edge, holds it until the block
   // takes it (start high, busy low at an edge), then books the expected
   // response beats. start stays high across a zero gap, so it is never
   // lowered and raised in the same step.
   task automatic drive_beat(input logic kind, input logic [DURATION_W-1:0] dur,
                             input logic [TAG_W-1:0] tag, input logic known,
                             input rsp_type typed);
      int gap;
      start           <= 1'b1;
      req_kind        <= kind;
      req_duration    <= dur;
      req_handler_tag <= tag;
      do @(posedge clock); while (busy);
      run_pool(kind, dur, tag);
      if (known) begin
         due_beats.push_back(typed);
      end else begin
         foreach (fresh[k]) due_beats.push_back(fresh[k]);
      end
      fresh.delete();
      issued++;
      if (kind == REQ_TICK) ticks_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic flag_miss(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $write("%0t %s: expected kind=%0d slot=%0d full=%0d tag=%02h run=%0d last=%0d",
                $realtime, what, want.kind, want.slot, want.full, want.tag,
                want.running, want.last);
         $display(", got kind=%0d slot=%0d full=%0d tag=%02h run=%0d last=%0d",
                  got.kind, got.slot, got.full, got.tag, got.running, got.last);
      end
   endtask

   // Response checker: every strobed beat is matched against the oldest
   // expectation. The block cannot be held off, so this just samples.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_strobe) begin
         got = '{rsp_result_kind, rsp_slot, rsp_pool_full, rsp_expired_tag,
                 rsp_source_running, rsp_last};
         beats_seen++;
         if (got.kind == RK_EXPIRED) expiries++;
         if (got.kind == RK_START && got.full) full_replies++;
         if (due_beats.size() == 0) begin
            flag_miss("response beat with none expected", '0, got);
         end else begin
            want = due_beats.pop_front();
            if (got != want) flag_miss("response beat mismatch", want, got);
         end
      end
   end

   initial begin
      rsp_type typed;
      int   n;
      bit   same;
      logic [DURATION_W-1:0] dur0;

      reset           = 1'b1;
      start           = 1'b0;
      req_kind        = REQ_START;
      req_duration    = '0;
      req_handler_tag = '0;
      tick_on         = 1'b0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
         count_left[i] = '0;
         tag_held[i]   = '0;
      end
      issued       = 0;
      ticks_sent   = 0;
      beats_seen   = 0;
      expiries     = 0;
      full_replies = 0;
      mismatches   = 0;
      steady       = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (plan[r]) begin
         typed = '{plan[r].rk, plan[r].slot, plan[r].full, 8'h00, plan[r].running, 1'b1};
         drive_beat(plan[r].kind, plan[r].dur, plan[r].tag, plan[r].known, typed);
      end

      // Random part. Most of it is well-formed: a burst of starts (sometimes
      // all the same duration so slots expire together) followed by ticks.
      // The rest is single beats of either kind. The duration field on ticks
      // is ignored by the block, so on burst ticks it carries full-width noise.
      while (issued < ITEMS) begin
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) != 0) begin
            n    = $urandom_range(1, 7);
            same = 1'($urandom_range(0, 1));
            dur0 = pick_duration();
            repeat (n)
               drive_beat(REQ_START, same ? dur0 : pick_duration(),
                          TAG_W'($urandom), 1'b0, '0);
            n = $urandom_range(1, 8);
            repeat (n)
               drive_beat(REQ_TICK, DURATION_W'($urandom), TAG_W'($urandom), 1'b0, '0);
         end else begin
            drive_beat(1'($urandom_range(0, 1)), DURATION_W'($urandom_range(0, 64)),
                       TAG_W'($urandom), 1'b0, '0);
         end
      end

      if (start) start <= 1'b0;

      // Drain: everything owed, then a walk's worth of quiet for stray beats.
      while (due_beats.size() != 0) @(posedge clock);
      repeat (POOL_SLOTS + 4) @(posedge clock);

      $display("Sent %0d request beats (%0d ticks); checked %0d response beats.",
               issued, ticks_sent, beats_seen);
      $display("Saw %0d slot expiries and %0d pool-full replies; %0d mismatches.",
               expiries, full_replies, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
